// ===== design/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// shared types and constants of the tlb and page table address translator
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // address layout: page in bits 15:8, offset in bits 7:0
    localparam int ADDR_BITS   = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = 8;
    localparam int FRAME_BITS  = 8;

    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int FRAME_COUNT = 1 << FRAME_BITS;
    localparam int PAGE_BYTES  = 1 << OFFSET_BITS;

    // default number of tlb slots
    localparam int TLB_DEPTH_DEF = 16;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the address and start the page table read
        logic commit;   // resolve the lookup, update state, load the result
    } cmd_t;

endpackage

// ===== design/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// logical to physical address translation through a tlb and a demand-paged
// page table with a wrapping free-frame allocator
// ----------------------------------------------------------------------------
//
//  channel | ports                         | direction | per transfer
//  --------+-------------------------------+-----------+---------------------
//  s_      | s_valid s_ready               | in        | logical address
//          | s_logical_address             |           |
//  m_      | m_valid m_ready               | out       | physical address,
//          | m_phys_addr m_tlb_hit         |           | tlb hit, page fault
//          | m_page_fault                  |           |
//
//  each address: accept starts the page table ram read; lookup runs the tlb
//  compare on the latched address, resolves and updates state
//  next address accepted the cycle after the result is loaded, even while
//  that result still waits on m_ready
//  a full result register holds the lookup cycle until m_ready
//  synchronous active-low reset clears tlb and page valid bits and the
//  free-frame counter at once; no clearing pass
//
module tlb_page_table_translator #(
    parameter int TLB_DEPTH = tlbpt_pkg::TLB_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input transfer
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tlbpt_pkg::ADDR_BITS-1:0] s_logical_address,

    // result transfer
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tlbpt_pkg::ADDR_BITS-1:0] m_phys_addr,
    output logic                            m_tlb_hit,
    output logic                            m_page_fault
);

    import tlbpt_pkg::*;

    // command bundle from sequencer to datapath
    cmd_t cmd;

    // sequencer: accept, then lookup/commit
    tlbpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // tlb, page table, allocator and result register
    tlbpt_dp #(
        .TLB_DEPTH (TLB_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_logical_address (s_logical_address),
        .m_phys_addr       (m_phys_addr),
        .m_tlb_hit         (m_tlb_hit),
        .m_page_fault      (m_page_fault)
    );

endmodule

// ===== design/tlbpt_ram.sv =====
// ----------------------------------------------------------------------------
// tlbpt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tlbpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// controller: two-state sequencer and result valid flag
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output tlbpt_pkg::cmd_t cmd
);

    import tlbpt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // result register must be free or emptying this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== design/tlbpt_dp.sv =====
// ----------------------------------------------------------------------------
// tlbpt_dp
// datapath: tlb slots with parallel compare, page table, frame allocator,
// result register
// ----------------------------------------------------------------------------
module tlbpt_dp #(
    parameter int TLB_DEPTH = tlbpt_pkg::TLB_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tlbpt_pkg::cmd_t                cmd,
    input  logic [tlbpt_pkg::ADDR_BITS-1:0] s_logical_address,
    output logic [tlbpt_pkg::ADDR_BITS-1:0] m_phys_addr,
    output logic                           m_tlb_hit,
    output logic                           m_page_fault
);

    import tlbpt_pkg::*;

    localparam int TIDX_W = $clog2(TLB_DEPTH);

    logic [ADDR_BITS-1:0]   addr_reg;
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offset;

    logic [PAGE_BITS-1:0]   tlb_page_reg  [TLB_DEPTH];
    logic [FRAME_BITS-1:0]  tlb_frame_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0]   tlb_valid_reg;

    logic [PAGE_COUNT-1:0]  page_valid_reg;
    logic [FRAME_BITS-1:0]  next_free_reg;
    logic [FRAME_BITS-1:0]  pt_frame;

    logic [TLB_DEPTH-1:0]   match;
    logic                   tlb_hit;
    logic [FRAME_BITS-1:0]  hit_frame;
    logic                   free_found;
    logic [TIDX_W-1:0]      free_idx;
    logic                   pt_hit;
    logic                   tlb_fill;
    logic                   fault;
    logic [FRAME_BITS-1:0]  frame;

    logic [ADDR_BITS-1:0]   phys_reg;
    logic                   tlb_hit_reg;
    logic                   fault_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= s_logical_address;
        end
    end

    assign page   = addr_reg[OFFSET_BITS +: PAGE_BITS];
    assign offset = addr_reg[OFFSET_BITS-1:0];

    // page table frames, read at accept time, written on a fault
    tlbpt_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (fault),
        .wr_addr (page),
        .wr_data (next_free_reg),
        .rd_en   (cmd.capture),
        .rd_addr (s_logical_address[OFFSET_BITS +: PAGE_BITS]),
        .rd_data (pt_frame)
    );

    // parallel compare, lowest matching slot wins
    always_comb begin
        hit_frame = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            match[i] = tlb_valid_reg[i] && (tlb_page_reg[i] == page);
            if (match[i]) begin
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    assign tlb_hit = |match;

    // first empty slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (!tlb_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = TIDX_W'(i);
            end
        end
    end

    assign pt_hit   = page_valid_reg[page];
    assign tlb_fill = cmd.commit && !tlb_hit && pt_hit;
    assign fault    = cmd.commit && !tlb_hit && !pt_hit;

    always_comb begin
        if (tlb_hit) begin
            frame = hit_frame;
        end else if (pt_hit) begin
            frame = pt_frame;
        end else begin
            frame = next_free_reg;
        end
    end

    // tlb payload
    always_ff @(posedge aclk) begin
        if (tlb_fill) begin
            if (free_found) begin
                for (int i = 0; i < TLB_DEPTH; i++) begin
                    if (free_idx == TIDX_W'(i)) begin
                        tlb_page_reg[i]  <= page;
                        tlb_frame_reg[i] <= pt_frame;
                    end
                end
            end else begin
                for (int i = TLB_DEPTH - 1; i > 0; i--) begin
                    tlb_page_reg[i]  <= tlb_page_reg[i-1];
                    tlb_frame_reg[i] <= tlb_frame_reg[i-1];
                end
                tlb_page_reg[0]  <= page;
                tlb_frame_reg[0] <= pt_frame;
            end
        end
    end

    // tlb valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlb_valid_reg <= '0;
        end else if (tlb_fill) begin
            if (free_found) begin
                for (int i = 0; i < TLB_DEPTH; i++) begin
                    if (free_idx == TIDX_W'(i)) begin
                        tlb_valid_reg[i] <= 1'b1;
                    end
                end
            end else begin
                tlb_valid_reg <= {tlb_valid_reg[TLB_DEPTH-2:0], 1'b1};
            end
        end
    end

    // page valid bits and frame allocator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_valid_reg <= '0;
            next_free_reg  <= '0;
        end else if (fault) begin
            page_valid_reg[page] <= 1'b1;
            next_free_reg        <= next_free_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            phys_reg    <= {frame, offset};
            tlb_hit_reg <= tlb_hit;
            fault_reg   <= !tlb_hit && !pt_hit;
        end
    end

    assign m_phys_addr  = phys_reg;
    assign m_tlb_hit    = tlb_hit_reg;
    assign m_page_fault = fault_reg;

endmodule

// ===== design/tlbpt_checker.sv =====
// ----------------------------------------------------------------------------
// tlbpt_checker
// port-level checks of the translator, bound to the top level
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [tlbpt_pkg::ADDR_BITS-1:0] s_logical_address,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tlbpt_pkg::ADDR_BITS-1:0] m_phys_addr,
    input logic                            m_tlb_hit,
    input logic                            m_page_fault
);

    // an accepted address blocks the input for its lookup cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted during lookup cycle");

    // a result is a tlb hit, a page fault, or neither, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tlb_hit && m_page_fault))
        else $error("tlb hit and page fault together");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phys_addr)
            && $stable(m_tlb_hit) && $stable(m_page_fault))
        else $error("stalled result changed");

endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tlb and page table address translator: a short
// list of directed addresses, then about nine hundred random ones built from
// tlb-resident pages, mapped pages, a page sweep and noise, all checked
// against an in-bench translation predictor under changing handshake pressure
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    localparam int TLB_SLOTS    = TLB_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 928;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 5000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES = 12;

    // idle chances per phase, in percent: none, sender, receiver, both
    localparam int SRC_IDLE   [PHASES] = '{0, 79, 0, 27};
    localparam int SINK_STALL [PHASES] = '{0, 0, 79, 27};

    // one translation outcome, as seen on the result channel
    typedef struct packed {
        logic [ADDR_BITS-1:0] phys;
        logic                 tlb_hit;
        logic                 page_fault;
    } xlat_t;

    // directed row: address, whether the outcome is typed in, typed outcome
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 typed;
        xlat_t                want;
    } probe_row_t;

    localparam int PROBE_ROWS = 22;
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        // fresh after reset: page 0 faults into frame 0
        '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        // top page faults into frame 1, offset all ones
        '{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1}},
        // page 0 now mapped but not in the tlb: plain page table hit
        '{16'h00AB, 1'b1, '{16'h00AB, 1'b0, 1'b0}},
        // page 0 was loaded into the tlb by the previous lookup
        '{16'h0012, 1'b1, '{16'h0012, 1'b1, 1'b0}},
        '{16'hFF00, 1'b1, '{16'h0100, 1'b0, 1'b0}},
        '{16'hFFFF, 1'b1, '{16'h01FF, 1'b1, 1'b0}},
        '{16'h7F55, 1'b1, '{16'h0255, 1'b0, 1'b1}},
        '{16'h80AA, 1'b1, '{16'h03AA, 1'b0, 1'b1}},
        '{16'h7F00, 1'b0, '0},
        '{16'h80FF, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'h55AA, 1'b0, '0},
        '{16'hAA55, 1'b0, '0},
        '{16'h5500, 1'b0, '0},
        '{16'hAAFF, 1'b0, '0},
        '{16'h0100, 1'b0, '0},
        '{16'hFE01, 1'b0, '0},
        '{16'h0180, 1'b0, '0},
        '{16'hFE7E, 1'b0, '0},
        '{16'h01FF, 1'b0, '0},
        '{16'h0000, 1'b0, '0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ADDR_BITS-1:0] s_logical_address;
    logic                 m_valid;
    logic                 m_ready;
    logic [ADDR_BITS-1:0] m_phys_addr;
    logic                 m_tlb_hit;
    logic                 m_page_fault;

    // predictor copy of the translation state
    logic [PAGE_BITS-1:0]  tlb_pg   [TLB_SLOTS];
    logic [FRAME_BITS-1:0] tlb_fr   [TLB_SLOTS];
    bit                    tlb_ok   [TLB_SLOTS];
    int                    tlb_used;
    logic [FRAME_BITS-1:0] pt_frame [PAGE_COUNT];
    bit                    pt_ok    [PAGE_COUNT];
    logic [FRAME_BITS-1:0] free_frame;

    // pages that have been given a frame, used to aim at page table hits
    logic [PAGE_BITS-1:0]  mapped_pages [$];
    logic [PAGE_BITS-1:0]  sweep_page;

    // outcomes of accepted addresses still waiting for their result transfer
    xlat_t pending_results [$];

    int mismatches     = 0;
    int idle_cycles    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_done      = 0;

    tlb_page_table_translator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_logical_address (s_logical_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_phys_addr       (m_phys_addr),
        .m_tlb_hit         (m_tlb_hit),
        .m_page_fault      (m_page_fault)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // translate one address and update the tlb, page table and allocator
    function automatic xlat_t translate_address(input logic [ADDR_BITS-1:0] la);
        logic [PAGE_BITS-1:0]   pg;
        logic [OFFSET_BITS-1:0] ofs;
        logic [FRAME_BITS-1:0]  fr;
        bit                     found;
        xlat_t                  r;
        pg           = PAGE_BITS'((int'(la) / PAGE_BYTES) % PAGE_COUNT);
        ofs          = OFFSET_BITS'(int'(la) % PAGE_BYTES);
        fr           = '0;
        found        = 1'b0;
        r.tlb_hit    = 1'b0;
        r.page_fault = 1'b0;
        // lowest matching slot wins
        for (int s = 0; s < TLB_SLOTS; s++) begin
            if (!found && tlb_ok[s] && tlb_pg[s] == pg) begin
                fr    = tlb_fr[s];
                found = 1'b1;
            end
        end
        if (found) begin
            r.tlb_hit = 1'b1;
        end else if (pt_ok[pg]) begin
            fr = pt_frame[pg];
            if (tlb_used < TLB_SLOTS) begin
                // slots fill in order, so the first empty one is at tlb_used
                tlb_pg[tlb_used] = pg;
                tlb_fr[tlb_used] = fr;
                tlb_ok[tlb_used] = 1'b1;
                tlb_used++;
            end else begin
                // full: every entry moves up one slot, the last slot's entry drops out
                for (int s = TLB_SLOTS - 1; s > 0; s--) begin
                    tlb_pg[s] = tlb_pg[s-1];
                    tlb_fr[s] = tlb_fr[s-1];
                    tlb_ok[s] = tlb_ok[s-1];
                end
                tlb_pg[0] = pg;
                tlb_fr[0] = fr;
                tlb_ok[0] = 1'b1;
            end
        end else begin
            // page fault: take the next free frame, tlb untouched
            fr           = free_frame;
            pt_frame[pg] = fr;
            pt_ok[pg]    = 1'b1;
            free_frame   = FRAME_BITS'((int'(fr) + 1) % FRAME_COUNT);
            mapped_pages.push_back(pg);
            r.page_fault = 1'b1;
        end
        r.phys = ADDR_BITS'(int'(fr) * PAGE_BYTES + int'(ofs));
        return r;
    endfunction

    // random address: tlb-resident page, mapped page, page sweep, or noise
    function automatic logic [ADDR_BITS-1:0] pick_address();
        int                   roll;
        logic [PAGE_BITS-1:0] pg;
        roll = $urandom_range(99);
        if (roll < 35 && tlb_used > 0) begin
            pg = tlb_pg[$urandom_range(tlb_used - 1)];
        end else if (roll < 55 && mapped_pages.size() > 0) begin
            pg = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
        end else if (roll < 90) begin
            // the sweep makes sure every page faults once, so the allocator wraps
            pg         = sweep_page;
            sweep_page = sweep_page + 1'b1;
        end else begin
            pg = PAGE_BITS'($urandom);
        end
        return ADDR_BITS'(int'(pg) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_BITS-1:0] got,
                                   input logic [ADDR_BITS-1:0] want);
        mismatches++;
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    // offer one address on the input channel and hold it until the transfer
    task automatic send_address(input logic [ADDR_BITS-1:0] la, input logic typed,
                                input xlat_t typed_result);
        xlat_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_logical_address <= la;
        do @(posedge aclk); while (!s_ready);
        // the predictor always runs so its state follows the block
        predicted = translate_address(la);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = hold_req;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // result checker: every result transfer against the oldest expectation
    always @(posedge aclk) begin : check_results
        xlat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", m_phys_addr, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_phys_addr !== want.phys)
                    report_mismatch("phys_addr", m_phys_addr, want.phys);
                if (m_tlb_hit !== want.tlb_hit)
                    report_mismatch("tlb_hit", ADDR_BITS'(m_tlb_hit), ADDR_BITS'(want.tlb_hit));
                if (m_page_fault !== want.page_fault)
                    report_mismatch("page_fault", ADDR_BITS'(m_page_fault),
                                    ADDR_BITS'(want.page_fault));
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        // known inputs from time zero, with reset held low at first
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_logical_address = '0;
        tlb_used          = 0;
        free_frame        = '0;
        sweep_page        = '0;
        for (int s = 0; s < TLB_SLOTS; s++) begin
            tlb_pg[s] = '0;
            tlb_fr[s] = '0;
            tlb_ok[s] = 1'b0;
        end
        for (int p = 0; p < PAGE_COUNT; p++) begin
            pt_frame[p] = '0;
            pt_ok[p]    = 1'b0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling
        foreach (PROBES[i])
            send_address(PROBES[i].addr, PROBES[i].typed, PROBES[i].want);

        // random part in idling phases; the first also gets the long hold-off
        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            if (ph == 0)
                hold_req++;
            repeat (RANDOM_ITEMS / PHASES)
                send_address(pick_address(), 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
